>>> src/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared widths, fixed-point constants, register indexes and the command and
// status groups that join the clipper controller and datapath.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam int CW   = 16;        // coordinate width
  localparam int NW   = CW + 1;    // width of a coordinate difference
  localparam int QF   = 16;        // fraction bits of a segment parameter
  localparam int PARW = QF + 4;    // parameter width, room for the sentinels
  localparam int QB   = QF + 3;    // raw quotient bits (one extra fraction bit)
  localparam int PW   = QF + 2 + NW; // product of parameter and difference
  localparam int IDXW = 3;         // config register index width

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [NW-1:0]   diff_t;
  typedef logic signed [PARW-1:0] param_t;
  typedef logic signed [PW-1:0]   prod_t;

  localparam param_t Q_ONE  = param_t'(64'sd1 <<< QF);
  localparam param_t Q_MAXV = param_t'((64'sd1 <<< (QF + 1)) - 1);
  localparam param_t Q_MINV = param_t'(-(64'sd1 <<< (QF + 1)));
  localparam param_t Q_INF  = param_t'(64'sd1 <<< (QF + 2));

  localparam logic [IDXW-1:0] REG_LEFT   = 3'd0;
  localparam logic [IDXW-1:0] REG_RIGHT  = 3'd1;
  localparam logic [IDXW-1:0] REG_BOTTOM = 3'd2;
  localparam logic [IDXW-1:0] REG_TOP    = 3'd3;
  localparam logic [IDXW-1:0] REG_POLY   = 3'd4;
  localparam logic [IDXW-1:0] REG_CLOSED = 3'd5;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_PEN   = 1'b1;

  // divider operand select, one per Liang-Barsky parameter
  localparam logic [1:0] DIV_XIN  = 2'd0;
  localparam logic [1:0] DIV_YIN  = 2'd1;
  localparam logic [1:0] DIV_XOUT = 2'd2;
  localparam logic [1:0] DIV_YOUT = 2'd3;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_cap;
    logic [1:0] div_idx;
    logic       mul0;
    logic       mul1;
    logic       fin;
    logic       decide;
    logic       out_en;
  } cmd_t;

  typedef struct packed {
    logic skip_div;
    logic div_done;
    logic out_done;
  } stat_t;

  function automatic diff_t ext1(input coord_t c);
    return {c[CW-1], c};
  endfunction

endpackage

>>> src/polygon_window_clipper_core.sv
// ----------------------------------------------------------------------------
// polygon_window_clipper_core
// Clips a vertex stream to a rectangular window.
// ----------------------------------------------------------------------------
// Input stream: one beat per vertex or end-of-stream marker (tuser = 1).
// Output stream: up to three beats per input beat, tlast on the final one;
// tuser marks a pen-up beat, which carries zero coordinates. An input beat
// that yields nothing produces no output beat.
// The window and mode registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must do so only while the block is idle (not enforced).
// One beat is worked at a time. A vertex that closes a segment runs four
// divisions through one shared radix-2 divider of 19 steps, then two
// multiplies before its first output beat.
// A first vertex or an end marker skips the divisions and multiplies.
// tready returns in the cycle after the last output beat is taken; a stalled
// receiver holds the block, and the output beat stays on the port.
// Reset sets the full window, line mode, and starts a new stream.
// ----------------------------------------------------------------------------
module polygon_window_clipper_core
  import pwc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IDXW-1:0] cfg_idx_i,
  input  logic [CW-1:0]   cfg_data_i,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [2*CW-1:0] s_axis_tdata_i,   // x_coord, y_coord
  input  logic            s_axis_tuser_i,   // action
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [2*CW-1:0] m_axis_tdata_o,   // out_x, out_y
  output logic            m_axis_tuser_o,   // kind
  output logic            m_axis_tlast_o
);

  cmd_t  cmd;
  stat_t stat;

  pwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pwc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o) else $error("input and output both open");

endmodule

>>> src/pwc_div.sv
// ----------------------------------------------------------------------------
// pwc_div
// Restoring radix-2 divider for one segment parameter: num / den in Q2.16,
// rounded to nearest with ties away from zero, saturated to [-2, 2).
// ----------------------------------------------------------------------------
module pwc_div
  import pwc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  diff_t  num_i,
  input  diff_t  den_i,
  output logic   done_o,
  output param_t quo_o
);

  localparam int CNTW = $clog2(QB);

  logic [NW-1:0]   num_mag, den_mag;
  logic            busy_q, done_q, neg_q, ovf_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   rem_q, dsr_q;
  logic [QB-1:0]   sh_q, quo_q;
  param_t          res_q;

  logic [NW:0]     t, diff;
  logic            ge;
  logic [QB-1:0]   qfin, rmag;
  logic [QB:0]     rsum;
  param_t          res_d;

  assign num_mag = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag = den_i[NW-1] ? (~den_i + 1'b1) : den_i;

  assign t    = {rem_q, sh_q[QB-1]};
  assign ge   = t >= {1'b0, dsr_q};
  assign diff = t - {1'b0, dsr_q};
  assign qfin = {quo_q[QB-2:0], ge};
  assign rsum = {1'b0, qfin} + 1'b1;
  assign rmag = rsum[QB:1];

  always_comb begin
    if (ovf_q) begin
      res_d = neg_q ? Q_MINV : Q_MAXV;
    end else if (!neg_q && ({1'b0, rmag} > Q_MAXV)) begin
      res_d = Q_MAXV;
    end else if (neg_q && ({1'b0, rmag} > -Q_MINV)) begin
      res_d = Q_MINV;
    end else if (neg_q) begin
      res_d = -$signed({1'b0, rmag});
    end else begin
      res_d = $signed({1'b0, rmag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(QB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1] ^ den_i[NW-1];
      ovf_q <= {2'b00, num_mag} >= {den_mag, 2'b00};
      dsr_q <= den_mag;
      rem_q <= num_mag >> 2;
      sh_q  <= {num_mag[1:0], {(QB-2){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[NW-1:0] : t[NW-1:0];
      sh_q  <= sh_q << 1;
      quo_q <= qfin;
      if (cnt_q == CNTW'(QB - 1)) begin
        res_q <= res_d;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("divider done held");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q)) else $error("done without a run");

endmodule

>>> src/pwc_datapath.sv
// ----------------------------------------------------------------------------
// pwc_datapath
// Window registers, stream state, parameter registers, intersection
// multiplier and the three-entry result buffer of the clipper.
// ----------------------------------------------------------------------------
module pwc_datapath
  import pwc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output stat_t           stat_o,
  input  logic            cfg_we_i,
  input  logic [IDXW-1:0] cfg_idx_i,
  input  logic [CW-1:0]   cfg_data_i,
  input  logic [2*CW-1:0] in_data_i,
  input  logic            in_user_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2*CW-1:0] out_data_o,
  output logic            out_user_o,
  output logic            out_last_o
);

  coord_t left_q, right_q, bottom_q, top_q;
  logic   poly_q, closed_q;

  coord_t x_q, y_q, px_q, py_q, sx_q, sy_q;
  logic   act_q, fp_q, ea_q;

  param_t par_q [4];
  logic   ent_ax_q, ext_ax_q;
  prod_t  prod_q;
  coord_t ent_q, ext_q;

  logic   rk_q [3];
  coord_t rx_q [3];
  coord_t ry_q [3];
  logic [1:0] cnt_q, rd_q;

  coord_t xmin, xmax, ymin, ymax;
  diff_t  dx, dy;
  coord_t xin, yin, xout, yout;
  diff_t  div_num, div_den;
  logic   div_done;
  param_t div_quo, sent;
  logic   zero_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= coord_t'(-(64'sd1 <<< (CW - 1)));
      right_q  <= coord_t'((64'sd1 <<< (CW - 1)) - 1);
      bottom_q <= coord_t'(-(64'sd1 <<< (CW - 1)));
      top_q    <= coord_t'((64'sd1 <<< (CW - 1)) - 1);
      poly_q   <= 1'b0;
      closed_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        REG_POLY:   poly_q   <= cfg_data_i[0];
        REG_CLOSED: closed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign xmin = (left_q < right_q) ? left_q : right_q;
  assign xmax = (left_q < right_q) ? right_q : left_q;
  assign ymin = (bottom_q < top_q) ? bottom_q : top_q;
  assign ymax = (bottom_q < top_q) ? top_q : bottom_q;

  assign dx = ext1(x_q) - ext1(px_q);
  assign dy = ext1(y_q) - ext1(py_q);

  // entry and exit edges per axis; a flat axis picks by where prev lies
  always_comb begin
    if (dx > 0) begin
      xin = xmin; xout = xmax;
    end else if (dx < 0) begin
      xin = xmax; xout = xmin;
    end else begin
      xin  = (px_q > xmax) ? xmin : xmax;
      xout = (px_q > xmax) ? xmax : xmin;
    end
    if (dy > 0) begin
      yin = ymin; yout = ymax;
    end else if (dy < 0) begin
      yin = ymax; yout = ymin;
    end else begin
      yin  = (py_q > ymax) ? ymin : ymax;
      yout = (py_q > ymax) ? ymax : ymin;
    end
  end

  always_comb begin
    case (cmd_i.div_idx)
      DIV_XIN: begin
        div_num = ext1(xin) - ext1(px_q);  div_den = dx;
        zero_d  = (dx == 0);  sent = -Q_INF;
      end
      DIV_YIN: begin
        div_num = ext1(yin) - ext1(py_q);  div_den = dy;
        zero_d  = (dy == 0);  sent = -Q_INF;
      end
      DIV_XOUT: begin
        div_num = ext1(xout) - ext1(px_q); div_den = dx;
        zero_d  = (dx == 0);
        sent    = (px_q < xmin || px_q > xmax) ? -Q_INF : Q_INF;
      end
      default: begin
        div_num = ext1(yout) - ext1(py_q); div_den = dy;
        zero_d  = (dy == 0);
        sent    = (py_q < ymin || py_q > ymax) ? -Q_INF : Q_INF;
      end
    endcase
  end

  pwc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  param_t axin, ayin, axout, ayout;
  assign axin  = par_q[0];
  assign ayin  = par_q[1];
  assign axout = par_q[2];
  assign ayout = par_q[3];

  // prev + round(param * delta), clamped to the axis range
  function automatic coord_t fin(input prod_t p, input coord_t base,
                                 input coord_t lo, input coord_t hi);
    logic [PW-1:0]             mag;
    logic [PW-1:0]             tmp;
    logic [PW-QF-1:0]          r;
    logic signed [PW-QF:0]     sv;
    logic signed [PW-QF+1:0]   sum;
    mag = p[PW-1] ? (~p + 1'b1) : p;
    tmp = mag + PW'(64'd1 << (QF - 1));
    r   = tmp[PW-1:QF];
    sv  = p[PW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    sum = (PW-QF+2)'(base) + (PW-QF+2)'(sv);
    if (sum < (PW-QF+2)'(lo)) begin
      return lo;
    end else if (sum > (PW-QF+2)'(hi)) begin
      return hi;
    end
    return sum[CW-1:0];
  endfunction

  logic signed [QF+1:0] mul_a;
  diff_t                mul_b;
  logic                 mul_ax;

  always_comb begin
    if (cmd_i.mul1) begin
      mul_ax = axout < ayout;
      mul_a  = mul_ax ? axout[QF+1:0] : ayout[QF+1:0];
      mul_b  = mul_ax ? dy : dx;
    end else begin
      mul_ax = axin > ayin;
      mul_a  = mul_ax ? axin[QF+1:0] : ayin[QF+1:0];
      mul_b  = mul_ax ? dy : dx;
    end
  end

  // ---- result decision -----------------------------------------------------
  logic   ck [4];
  logic   cen [4];
  coord_t cx [4];
  coord_t cy [4];
  logic   rk_d [3];
  coord_t rx_d [3];
  coord_t ry_d [3];
  logic [1:0] n_d;
  logic   ea_d, st_upd;
  coord_t sx_d, sy_d;

  param_t ain1, ain2, aout1;
  logic   go, degen, main, in_win;

  always_comb begin
    ain1  = (axin < ayin) ? axin : ayin;
    ain2  = (axin < ayin) ? ayin : axin;
    aout1 = (axout < ayout) ? axout : ayout;
    go    = (ain1 <= Q_ONE) && (ain2 <= Q_ONE);
    degen = (ain2 <= 0) && (aout1 <= 0);
    main  = go && !degen && (ain2 <= aout1);
    in_win = (x_q >= xmin) && (x_q <= xmax) && (y_q >= ymin) && (y_q <= ymax);

    for (int i = 0; i < 4; i++) begin
      ck[i] = KIND_POINT; cen[i] = 1'b0; cx[i] = '0; cy[i] = '0;
    end
    ck[3] = KIND_PEN;

    if (act_q) begin
      cen[2] = poly_q && closed_q && ea_q;
      cx[2]  = sx_q; cy[2] = sy_q;
      cen[3] = 1'b1;
    end else if (fp_q) begin
      cen[2] = in_win;
      cx[2]  = x_q; cy[2] = y_q;
    end else begin
      // corner before entering
      cen[0] = (ain1 <= Q_ONE) && (ain1 > 0) && poly_q;
      cx[0]  = xin; cy[0] = yin;
      // entry intersection
      cen[1] = main && (ain2 > 0);
      cx[1]  = ent_ax_q ? xin : ent_q;
      cy[1]  = ent_ax_q ? ent_q : yin;
      // exit intersection, end point or turning corner
      if (main) begin
        cen[2] = 1'b1;
        if (aout1 < Q_ONE) begin
          cx[2] = ext_ax_q ? xout : ext_q;
          cy[2] = ext_ax_q ? ext_q : yout;
        end else begin
          cx[2] = x_q; cy[2] = y_q;
        end
      end else begin
        cen[2] = go && !degen && poly_q;
        cx[2]  = (axin > ayin) ? xin : xout;
        cy[2]  = (axin > ayin) ? yout : yin;
      end
      // pen-up: leaving the window, or exit right at the start point
      cen[3] = !poly_q && ((main && (aout1 < Q_ONE)) || (go && degen && (aout1 == 0)));
    end

    n_d = '0;
    for (int i = 0; i < 3; i++) begin
      rk_d[i] = KIND_POINT; rx_d[i] = '0; ry_d[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cen[i] && n_d != 2'd3) begin
        rk_d[n_d] = ck[i];
        rx_d[n_d] = cx[i];
        ry_d[n_d] = cy[i];
        n_d = n_d + 1'b1;
      end
    end

    sx_d = cx[2]; sy_d = cy[2];
    if (cen[1]) begin
      sx_d = cx[1]; sy_d = cy[1];
    end
    if (cen[0]) begin
      sx_d = cx[0]; sy_d = cy[0];
    end
    st_upd = !act_q && !ea_q && poly_q && closed_q && (cen[0] || cen[1] || cen[2]);
    ea_d   = act_q ? 1'b0 : (ea_q || cen[0] || cen[1] || cen[2]);
  end

  // ---- registers -----------------------------------------------------------
  logic out_hs, out_last;

  assign out_valid_o = cmd_i.out_en && (rd_q != cnt_q);
  assign out_last    = (rd_q == cnt_q - 1'b1);
  assign out_hs      = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q  <= 1'b1;
      ea_q  <= 1'b0;
      px_q  <= '0;
      py_q  <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      if (cmd_i.decide) begin
        cnt_q <= n_d;
        rd_q  <= '0;
        ea_q  <= ea_d;
        fp_q  <= act_q;
        if (!act_q) begin
          px_q <= x_q;
          py_q <= y_q;
        end
        if (st_upd) begin
          sx_q <= sx_d;
          sy_q <= sy_d;
        end
      end else if (out_hs) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_user_i;
      x_q   <= in_data_i[CW-1:0];
      y_q   <= in_data_i[2*CW-1:CW];
    end
    if (cmd_i.div_cap) begin
      par_q[cmd_i.div_idx] <= zero_d ? sent : div_quo;
    end
    if (cmd_i.mul0) begin
      ent_ax_q <= mul_ax;
      prod_q   <= mul_a * mul_b;
    end
    if (cmd_i.mul1) begin
      ent_q    <= ent_ax_q ? fin(prod_q, py_q, ymin, ymax) : fin(prod_q, px_q, xmin, xmax);
      ext_ax_q <= mul_ax;
      prod_q   <= mul_a * mul_b;
    end
    if (cmd_i.fin) begin
      ext_q <= ext_ax_q ? fin(prod_q, py_q, ymin, ymax) : fin(prod_q, px_q, xmin, xmax);
    end
    if (cmd_i.decide) begin
      for (int i = 0; i < 3; i++) begin
        rk_q[i] <= rk_d[i];
        rx_q[i] <= rx_d[i];
        ry_q[i] <= ry_d[i];
      end
    end
  end

  assign out_data_o = {ry_q[rd_q], rx_q[rd_q]};
  assign out_user_o = rk_q[rd_q];
  assign out_last_o = out_last;

  assign stat_o.skip_div = act_q || fp_q;
  assign stat_o.div_done = div_done;
  assign stat_o.out_done = (cnt_q == 2'd0) || (out_hs && out_last);

  a_pen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_user_o == KIND_PEN |-> out_data_o == '0)
    else $error("pen-up beat with nonzero data");
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_en |-> rd_q <= cnt_q) else $error("read index past count");

endmodule

>>> src/pwc_ctrl.sv
// ----------------------------------------------------------------------------
// pwc_ctrl
// Sequencer of the clipper: accepts one beat, runs four parameter divisions
// and two intersection products if it closes a segment, drains the results.
// ----------------------------------------------------------------------------
module pwc_ctrl
  import pwc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEL  = 4'd1;
  localparam logic [3:0] S_DST  = 4'd2;
  localparam logic [3:0] S_DWT  = 4'd3;
  localparam logic [3:0] S_M0   = 4'd4;
  localparam logic [3:0] S_M1   = 4'd5;
  localparam logic [3:0] S_M2   = 4'd6;
  localparam logic [3:0] S_DEC  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.div_idx = idx_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = DIV_XIN;
          state_d    = S_SEL;
        end
      end
      S_SEL: state_d = stat_i.skip_div ? S_DEC : S_DST;
      S_DST: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DWT;
      end
      S_DWT: begin
        if (stat_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          if (idx_q == DIV_YOUT) begin
            state_d = S_M0;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_DST;
          end
        end
      end
      S_M0: begin
        cmd_o.mul0 = 1'b1;
        state_d = S_M1;
      end
      S_M1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_M2;
      end
      S_M2: begin
        cmd_o.fin = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.out_en = 1'b1;
        if (stat_i.out_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_start_in_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == S_DWT && !stat_i.div_done)
    else $error("divider start out of sequence");
  a_cap_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_cap && idx_q == DIV_YOUT |=> cmd_o.mul0)
    else $error("multiply did not follow last division");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o) else $error("ready after accept");

endmodule

>>> tb/tb_polygon_window_clipper_core.sv
// ----------------------------------------------------------------------------
// tb_polygon_window_clipper_core
// Self-checking bench for the window clipper. A directed table covers the
// edge cases, then random vertex streams run under several window and mode
// settings. Every output beat is checked against a bit-accurate predictor.
// ----------------------------------------------------------------------------
module tb_polygon_window_clipper_core;
  import pwc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QONE  = 65536;
  localparam longint QSAT  = 131071;
  localparam longint QNEG  = -131072;
  localparam longint QSENT = 64'd1 << 24;
  localparam int     DRAIN = 150;

  typedef enum bit {ROW_BEAT, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e         op;
    logic            act;
    logic [CW-1:0]   x;
    logic [CW-1:0]   y;
    logic [IDXW-1:0] idx;
    bit              chk;
    logic            ek;
    logic [CW-1:0]   ex;
    logic [CW-1:0]   ey;
  } row_t;

  typedef struct {
    logic          kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
  } clip_out_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [IDXW-1:0] cfg_idx;
  logic [CW-1:0]   cfg_data;
  logic            s_tvalid;
  logic            s_tready;
  logic [2*CW-1:0] s_tdata;  // x_coord, y_coord
  logic            s_tuser;  // action
  logic            m_tvalid;
  logic            m_tready;
  logic [2*CW-1:0] m_tdata;  // out_x, out_y
  logic            m_tuser;  // kind
  logic            m_tlast;

  polygon_window_clipper_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // predictor state
  longint    win_l, win_r, win_b, win_t;
  bit        poly_m, closed_m;
  bit        first_pend, emitted;
  longint    px, py, sx, sy;
  clip_out_t step_res[$];
  clip_out_t clip_q[$];

  int  errors;
  bit  no_idle;
  bit  hold_req;
  row_t rows[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  task automatic report(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function automatic longint rdiv(input longint num, input longint den);
    longint unsigned mag, q;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    mag = (num < 0) ? longint'(-num) : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint qparam(input longint num, input longint den);
    longint q;
    q = rdiv(num * QONE, den);
    if (q > QSAT) q = QSAT;
    if (q < QNEG) q = QNEG;
    return q;
  endfunction

  function automatic longint clampv(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void put_res(input logic k, input longint x, input longint y);
    clip_out_t r;
    r.kind = k;
    r.x    = x[CW-1:0];
    r.y    = y[CW-1:0];
    r.last = 1'b0;
    if (step_res.size() < 3) step_res.push_back(r);
  endfunction

  function automatic void put_point(input longint x, input longint y);
    if (!emitted) begin
      emitted = 1'b1;
      if (poly_m && closed_m) begin
        sx = x;
        sy = y;
      end
    end
    put_res(KIND_POINT, x, y);
  endfunction

  function automatic void clip_seg(input longint x, input longint y, input longint xmin,
                                   input longint xmax, input longint ymin,
                                   input longint ymax);
    longint dx, dy, xin, yin, xout, yout, axin, ayin, axout, ayout;
    longint ain1, ain2, aout1, xx, yy;
    dx = x - px;
    dy = y - py;
    if (dx > 0) begin xin = xmin; axin = qparam(xin - px, dx); end
    else if (dx < 0) begin xin = xmax; axin = qparam(xin - px, dx); end
    else begin axin = -QSENT; xin = (px > xmax) ? xmin : xmax; end
    if (dy > 0) begin yin = ymin; ayin = qparam(yin - py, dy); end
    else if (dy < 0) begin yin = ymax; ayin = qparam(yin - py, dy); end
    else begin ayin = -QSENT; yin = (py > ymax) ? ymin : ymax; end
    ain1 = (axin < ayin) ? axin : ayin;
    ain2 = (axin < ayin) ? ayin : axin;
    if (ain1 > QONE) return;
    if (ain1 > 0 && poly_m) put_point(xin, yin);
    if (ain2 > QONE) return;
    if (dx > 0) begin xout = xmax; axout = qparam(xout - px, dx); end
    else if (dx < 0) begin xout = xmin; axout = qparam(xout - px, dx); end
    else begin
      axout = (px < xmin || px > xmax) ? -QSENT : QSENT;
      xout = (px > xmax) ? xmax : xmin;
    end
    if (dy > 0) begin yout = ymax; ayout = qparam(yout - py, dy); end
    else if (dy < 0) begin yout = ymin; ayout = qparam(yout - py, dy); end
    else begin
      ayout = (py < ymin || py > ymax) ? -QSENT : QSENT;
      yout = (py > ymax) ? ymax : ymin;
    end
    aout1 = (axout < ayout) ? axout : ayout;
    if (ain2 <= 0 && aout1 <= 0) begin
      if (aout1 == 0 && !poly_m) put_res(KIND_PEN, 0, 0);
      return;
    end
    if (ain2 <= aout1) begin
      if (ain2 > 0) begin
        if (axin > ayin) begin
          xx = xin;
          yy = clampv(py + rdiv(axin * dy, QONE), ymin, ymax);
        end else begin
          xx = clampv(px + rdiv(ayin * dx, QONE), xmin, xmax);
          yy = yin;
        end
        put_point(xx, yy);
      end
      if (aout1 < QONE) begin
        if (axout < ayout) begin
          xx = xout;
          yy = clampv(py + rdiv(axout * dy, QONE), ymin, ymax);
        end else begin
          xx = clampv(px + rdiv(ayout * dx, QONE), xmin, xmax);
          yy = yout;
        end
        put_point(xx, yy);
        if (!poly_m) put_res(KIND_PEN, 0, 0);
      end else begin
        put_point(x, y);
      end
    end else if (poly_m) begin
      if (axin > ayin) put_point(xin, yout);
      else put_point(xout, yin);
    end
  endfunction

  // works out the beats caused by one accepted input beat
  function automatic void predict_clip(input logic act, input logic [CW-1:0] xr,
                                       input logic [CW-1:0] yr);
    longint xmin, xmax, ymin, ymax, x, y;
    xmin = (win_l < win_r) ? win_l : win_r;
    xmax = (win_l < win_r) ? win_r : win_l;
    ymin = (win_b < win_t) ? win_b : win_t;
    ymax = (win_b < win_t) ? win_t : win_b;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    step_res.delete();
    if (act) begin
      if (poly_m && closed_m && emitted) put_res(KIND_POINT, sx, sy);
      put_res(KIND_PEN, 0, 0);
      first_pend = 1'b1;
      emitted = 1'b0;
    end else begin
      if (first_pend) begin
        first_pend = 1'b0;
        if (x >= xmin && x <= xmax && y >= ymin && y <= ymax) put_point(x, y);
      end else begin
        clip_seg(x, y, xmin, xmax, ymin, ymax);
      end
      px = x;
      py = y;
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[i]) clip_q.push_back(step_res[i]);
  endfunction

  task automatic send_beat(input logic act, input logic [CW-1:0] x, input logic [CW-1:0] y);
    cfg_we <= 1'b0;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {y, x};
    do @(posedge clk_i); while (!s_tready);
    predict_clip(act, x, y);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    cfg_we   <= 1'b0;
    while (clip_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // leaves cfg_we high; the next bench action lowers it
  task automatic cfg_write(input logic [IDXW-1:0] idx, input logic [CW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_LEFT:   win_l = longint'($signed(val));
      REG_RIGHT:  win_r = longint'($signed(val));
      REG_BOTTOM: win_b = longint'($signed(val));
      REG_TOP:    win_t = longint'($signed(val));
      REG_POLY:   poly_m = val[0];
      REG_CLOSED: closed_m = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic void add_beat(input logic act, input int x, input int y, input bit chk,
                                   input logic ek, input int ex, input int ey);
    row_t r;
    r.op = ROW_BEAT; r.act = act; r.x = x[CW-1:0]; r.y = y[CW-1:0]; r.idx = '0;
    r.chk = chk; r.ek = ek; r.ex = ex[CW-1:0]; r.ey = ey[CW-1:0];
    rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [IDXW-1:0] idx, input int val);
    row_t r;
    r.op = ROW_CFG; r.act = 1'b0; r.x = val[CW-1:0]; r.y = '0; r.idx = idx;
    r.chk = 1'b0; r.ek = 1'b0; r.ex = '0; r.ey = '0;
    rows.push_back(r);
  endfunction

  function automatic logic [CW-1:0] pick_coord(input longint a, input longint b);
    longint lo, hi, v;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if ($urandom_range(0, 4) < 3) begin
      lo = clampv(lo - 64, -32768, 32767);
      hi = clampv(hi + 64, -32768, 32767);
      v = lo + longint'($urandom_range(0, 32'(hi - lo)));
      return v[CW-1:0];
    end
    return CW'($urandom());
  endfunction

  function automatic logic [CW-1:0] pick_edge();
    int v;
    v = int'($urandom_range(0, 4000)) - 2000;
    return v[CW-1:0];
  endfunction

  always @(posedge clk_i) begin
    clip_out_t e;
    if (rst_ni && m_tvalid && m_tready) begin
      if (clip_q.size() == 0) begin
        report($sformatf("beat with nothing expected: tdata=%h", m_tdata));
      end else begin
        e = clip_q.pop_front();
        if (m_tuser !== e.kind || m_tdata !== {e.y, e.x} || m_tlast !== e.last)
          report($sformatf("got kind=%b x=%0d y=%0d last=%b, want kind=%b x=%0d y=%0d last=%b",
                           m_tuser, $signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]),
                           m_tlast, e.kind, $signed(e.x), $signed(e.y), e.last));
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        for (n = 0; n < 400; n++) @(posedge clk_i);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [CW-1:0] x, y;
    errors = 0; no_idle = 0; hold_req = 0;
    rst_ni = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    win_l = -32768; win_r = 32767; win_b = -32768; win_t = 32767;
    poly_m = 0; closed_m = 0; first_pend = 1; emitted = 0;
    px = 0; py = 0; sx = 0; sy = 0;

    // reset window is the full coordinate range
    add_beat(0, -32768, -32768, 1, KIND_POINT, -32768, -32768);
    add_beat(0, 32767, 32767, 1, KIND_POINT, 32767, 32767);
    add_beat(1, 0, 0, 1, KIND_PEN, 0, 0);
    add_beat(0, 32767, -32768, 1, KIND_POINT, 32767, -32768);
    add_beat(0, -32768, 32767, 0, 0, 0, 0);
    add_beat(1, -1, -1, 1, KIND_PEN, 0, 0);
    add_cfg(REG_LEFT, -100); add_cfg(REG_RIGHT, 100);
    add_cfg(REG_BOTTOM, -100); add_cfg(REG_TOP, 100);
    add_cfg(REG_POLY, 1); add_cfg(REG_CLOSED, 1);
    add_beat(0, 0, 0, 1, KIND_POINT, 0, 0);
    add_beat(0, 200, 0, 1, KIND_POINT, 100, 0);
    add_beat(0, 200, 200, 0, 0, 0, 0);     // fully outside: nothing
    add_beat(0, -200, 50, 0, 0, 0, 0);
    add_beat(0, 5, 5, 0, 0, 0, 0);
    add_beat(0, 5, 5, 1, KIND_POINT, 5, 5); // repeated point inside
    add_beat(1, 0, 0, 1, KIND_POINT, 0, 0); // closed: start point again
    // swapped vertical edges, line mode
    add_cfg(REG_LEFT, 100); add_cfg(REG_RIGHT, -100); add_cfg(REG_POLY, 0);
    add_beat(0, 100, 0, 1, KIND_POINT, 100, 0);
    add_beat(0, 200, 0, 1, KIND_PEN, 0, 0); // exit right at the start
    add_beat(1, 0, 0, 1, KIND_PEN, 0, 0);
    add_beat(0, -32768, 32767, 0, 0, 0, 0);
    add_beat(0, 32767, -32768, 0, 0, 0, 0);
    add_beat(1, 0, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].op == ROW_CFG) begin
        wait_idle();
        cfg_write(rows[i].idx, rows[i].x);
      end else begin
        send_beat(rows[i].act, rows[i].x, rows[i].y);
        if (rows[i].chk && (step_res.size() == 0 || step_res[0].kind !== rows[i].ek ||
            step_res[0].x !== rows[i].ex || step_res[0].y !== rows[i].ey))
          report($sformatf("directed row %0d: predictor disagrees with table", i));
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      if (ph == 0) begin
        cfg_write(REG_LEFT, 16'h8000); cfg_write(REG_RIGHT, 16'h7fff);
        cfg_write(REG_BOTTOM, 16'h7fff); cfg_write(REG_TOP, 16'h8000);
        cfg_write(REG_POLY, 1); cfg_write(REG_CLOSED, 1);
      end else begin
        cfg_write(REG_LEFT, pick_edge()); cfg_write(REG_RIGHT, pick_edge());
        cfg_write(REG_BOTTOM, pick_edge()); cfg_write(REG_TOP, pick_edge());
        cfg_write(REG_POLY, CW'($urandom_range(0, 1)));
        cfg_write(REG_CLOSED, CW'(ph != 2));
      end
      for (int k = 0; k < 25; k++) begin
        if (ph == 1 && k == 10) hold_req = 1'b1;
        if (ph == 3 && k == 15) no_idle = 1'b1;
        x = pick_coord(win_l, win_r);
        y = pick_coord(win_b, win_t);
        send_beat($urandom_range(0, 7) == 0, x, y);
      end
      send_beat(1'b1, CW'($urandom()), CW'($urandom()));
    end

    wait_idle();
    if (errors == 0 && clip_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
